@@ hw/rtl/ctca_pkg.sv @@
// ----------------------------------------------------------------------------
// ctca_pkg
// shared field widths, operation and status codes for the clearable array
// ----------------------------------------------------------------------------
package ctca_pkg;

  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int SIZE_W = 11;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam kind_t KIND_WRITE = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_UNINIT  = 2'd1;
  localparam status_t ST_INVALID = 2'd2;

endpackage

@@ hw/rtl/ctca_ram.sv @@
// ----------------------------------------------------------------------------
// ctca_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ctca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  // two-state storage: contents never matter before they are written
  bit   [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/ctca_cfg.sv @@
// ----------------------------------------------------------------------------
// ctca_cfg
// apb register slice holding the array size
// ----------------------------------------------------------------------------
module ctca_cfg
  import ctca_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [1:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output logic [SIZE_W-1:0] array_size
);

  localparam logic [1:0] ADDR_ARRAY_SIZE = 2'd0;

  logic [SIZE_W-1:0] array_size_r;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr == ADDR_ARRAY_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      array_size_r <= SIZE_RESET;
    end else if (wr_en) begin
      array_size_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_ARRAY_SIZE) begin
      cfg_prdata = {{(32-SIZE_W){1'b0}}, array_size_r};
    end
  end

  assign array_size = array_size_r;

endmodule

@@ hw/rtl/ctca_engine.sv @@
// ----------------------------------------------------------------------------
// ctca_engine
// per-word sequencer: slot lookup, stack check, write-back and result register
// ----------------------------------------------------------------------------
module ctca_engine
  import ctca_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] array_size,
  // input words
  input  logic              in_tvalid,
  output logic              in_tready,
  input  kind_t             in_kind,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [VAL_W-1:0]  in_value,
  // results
  output logic              out_tvalid,
  input  logic              out_tready,
  output status_t           out_status,
  output logic [VAL_W-1:0]  out_value,
  // entry memory: {data, slot} per position
  output logic              ent_we,
  output logic [AW-1:0]     ent_waddr,
  output logic [VAL_W+AW-1:0] ent_wdata,
  output logic              ent_re,
  output logic [AW-1:0]     ent_raddr,
  input  logic [VAL_W+AW-1:0] ent_rdata,
  // stack memory: position per slot
  output logic              stk_we,
  output logic [AW-1:0]     stk_waddr,
  output logic [IDX_W-1:0]  stk_wdata,
  output logic              stk_re,
  output logic [AW-1:0]     stk_raddr,
  input  logic [IDX_W-1:0]  stk_rdata
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOK   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  localparam int unsigned DEPTH_U = DEPTH;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [1:0]         state_r, state_nxt;
  kind_t              kind_r;
  logic [IDX_W-1:0]   index_r;
  logic [VAL_W-1:0]   wval_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [VAL_W-1:0]   out_value_r, out_value_nxt;

  logic [IDX_W+AW-1:0] in_ext, idx_ext;
  logic [AW-1:0]       in_addr, idx_addr;
  logic [AW-1:0]       slot;
  logic [VAL_W-1:0]    data_rd;
  logic                accept, advance, live, bad_pos, has_room;
  logic [AW-1:0]       new_slot;

  assign in_ext   = {{AW{1'b0}}, in_index};
  assign in_addr  = in_ext[AW-1:0];
  assign idx_ext  = {{AW{1'b0}}, index_r};
  assign idx_addr = idx_ext[AW-1:0];

  assign slot    = ent_rdata[AW-1:0];
  assign data_rd = ent_rdata[VAL_W+AW-1:AW];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign advance   = (state_r == S_DECIDE) && (!out_valid_r || out_tready);

  // position is live when its slot is below the count and the stack points back
  assign live     = (CW'(slot) < count_r) && (stk_rdata == index_r);
  assign bad_pos  = ({1'b0, index_r} >= array_size) || (32'(index_r) >= DEPTH_U);
  assign has_room = (count_r < DEPTH_C);
  assign new_slot = (!live && has_room) ? count_r[AW-1:0] : slot;

  // first read: slot and data of the addressed position
  assign ent_re    = accept;
  assign ent_raddr = in_addr;
  // second read: stack entry named by that slot
  assign stk_re    = (state_r == S_LOOK);
  assign stk_raddr = slot;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    ent_we         = 1'b0;
    ent_waddr      = idx_addr;
    ent_wdata      = {wval_r, new_slot};
    stk_we         = 1'b0;
    stk_waddr      = count_r[AW-1:0];
    stk_wdata      = index_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (advance) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = '0;
          if (kind_r == KIND_CLEAR) begin
            count_nxt = '0;
          end else if (kind_r == KIND_WRITE || kind_r == KIND_READ) begin
            if (bad_pos) begin
              out_status_nxt = ST_INVALID;
            end else if (kind_r == KIND_WRITE) begin
              ent_we = 1'b1;
              if (!live && has_room) begin
                stk_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end else if (live) begin
              out_value_nxt = data_rd;
            end else begin
              out_status_nxt = ST_UNINIT;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      index_r <= in_index;
      wval_r  <= in_value;
    end
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule

@@ hw/rtl/constant_time_clear_array_top.sv @@
// ----------------------------------------------------------------------------
// constant_time_clear_array_top
// array of signed words with a clear that takes one operation
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one operation per word. in_tuser carries the kind (write, read,
//           clear all), in_tdata carries index and write value.
//   out_* : one result word per operation, in order. out_tuser carries the
//           status (ok, not initialized, invalid position), out_tdata the
//           value of a successful read, zero otherwise.
//   cfg_* : apb register at byte address 0 holds the array size; indices at
//           or above it, or at or above DEPTH, answer invalid position.
// timing:
//   words are taken one at a time, only while idle. the entry memory is read for
//   the position's slot, then the stack memory is read at that slot; the decision
//   and write-back happen in the decision step. the result is registered in an
//   output register, and the next word is taken while it waits there.
// reset:
//   clears the live count and sets the array size to 1024; memory contents
//   are never cleared since the live count and stack decide what is valid.
// stall:
//   if the receiver holds out_tready low with a result pending, the next
//   word waits in its decision step and in_tready stays low until it drains.
// ----------------------------------------------------------------------------
module constant_time_clear_array_top
  import ctca_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [9:0] index, [41:10] write_value, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_value
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SIZE_W-1:0] array_size;

  // entry memory: data word above, slot number below
  logic                 ent_we, ent_re;
  logic [AW-1:0]        ent_waddr, ent_raddr;
  logic [VAL_W+AW-1:0]  ent_wdata, ent_rdata;

  // stack of live positions
  logic                 stk_we, stk_re;
  logic [AW-1:0]        stk_waddr, stk_raddr;
  logic [IDX_W-1:0]     stk_wdata, stk_rdata;

  status_t              out_status;

  ctca_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .array_size  (array_size)
  );

  ctca_ram #(
    .WIDTH (VAL_W + AW),
    .DEPTH (DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  ctca_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DEPTH)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  ctca_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .array_size (array_size),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .in_index   (in_tdata[IDX_W-1:0]),
    .in_value   (in_tdata[IDX_W+VAL_W-1:IDX_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_status),
    .out_value  (out_tdata),
    .ent_we     (ent_we),
    .ent_waddr  (ent_waddr),
    .ent_wdata  (ent_wdata),
    .ent_re     (ent_re),
    .ent_raddr  (ent_raddr),
    .ent_rdata  (ent_rdata),
    .stk_we     (stk_we),
    .stk_waddr  (stk_waddr),
    .stk_wdata  (stk_wdata),
    .stk_re     (stk_re),
    .stk_raddr  (stk_raddr),
    .stk_rdata  (stk_rdata)
  );

  assign out_tuser = out_status;

endmodule

@@ tb/constant_time_clear_array_top_tb.sv @@
// ----------------------------------------------------------------------------
// constant_time_clear_array_top_tb
// self-checking bench for the clearable array: write, read, clear and spare
// kinds, array size settings from zero to above the depth, random input gaps and
// result back-pressure, and an in-bench model of the stack-based live tracking
// ----------------------------------------------------------------------------
module constant_time_clear_array_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctca_pkg::*;

  localparam int DEPTH = 1024;
  localparam int IDLE_LIMIT = 4000;   // cycles with no handshake anywhere
  localparam int SETTLE = 8;          // edges to wait after the last result

  // spare kind, answered with ok and zero
  localparam kind_t KIND_SPARE = 2'd3;
  // register byte address
  localparam logic [1:0] ADDR_ARRAY_SIZE = 2'd0;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
  } array_result_t;

  // --------------------------------------------------------------------------
  // expected-result tracker: its own copy of the live count, slot stack,
  // back-pointers and stored values
  // --------------------------------------------------------------------------
  class array_scoreboard;
    logic [10:0] size_limit;
    logic [10:0] live_count;
    logic [9:0]  stack_pos [DEPTH];
    logic [10:0] slot_of   [DEPTH];
    logic [31:0] stored    [DEPTH];
    array_result_t pending_results[$];
    int errors;

    function new();
      size_limit = SIZE_RESET;
      live_count = '0;
      errors = 0;
      foreach (stack_pos[i]) begin
        stack_pos[i] = '0;
        slot_of[i] = '0;
        stored[i] = '0;
      end
    endfunction

    function void set_size(logic [10:0] v);
      size_limit = v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // live when the back-pointer names a live slot that points back here
    function bit is_live(logic [9:0] pos);
      logic [10:0] slot;
      slot = slot_of[pos];
      if (slot >= live_count || slot >= DEPTH) return 1'b0;
      return stack_pos[slot] == pos;
    endfunction

    function void note_op(kind_t kind, logic [9:0] pos, logic [31:0] wval);
      array_result_t r;
      r.status = ST_OK;
      r.value = '0;
      case (kind)
        KIND_CLEAR: begin
          live_count = '0;
        end
        KIND_WRITE, KIND_READ: begin
          if (pos >= size_limit || pos >= DEPTH) begin
            r.status = ST_INVALID;
          end else if (kind == KIND_WRITE) begin
            stored[pos] = wval;
            if (!is_live(pos) && live_count < DEPTH) begin
              stack_pos[live_count] = pos;
              slot_of[pos] = live_count;
              live_count = live_count + 1'b1;
            end
          end else if (is_live(pos)) begin
            r.value = stored[pos];
          end else begin
            r.status = ST_UNINIT;
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(status_t status, logic [31:0] value);
      array_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, status %0d value %h",
                 $time, status, value);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d, actual %0d", $time, e.status, status);
        errors++;
      end
      if (value !== e.value) begin
        $display("%0t: read value expected %h, actual %h", $time, e.value, value);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // dut signals
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;    // [9:0] index, [41:10] write_value, rest zero
  logic [1:0]  in_tuser;    // [1:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [31:0] read_value
  logic [1:0]  out_tuser;   // [1:0] status
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  array_scoreboard sb = new();

  bit tx_free;      // no gaps on the input side when set
  bit rx_free;      // no stalls on the result side when set
  int rx_hold;
  int rx_roll;
  int idle_cycles;

  constant_time_clear_array_top #(.DEPTH(DEPTH)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: ready mostly high, short stalls often, long ones now and then
  always @(posedge clk) begin
    if (rx_free) begin
      out_tready <= 1'b1;
      rx_hold = 0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 75) begin
        out_tready <= 1'b1;
      end else if (rx_roll < 95) begin
        out_tready <= 1'b0;
        rx_hold = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        rx_hold = $urandom_range(10, 40);
      end
    end
  end

  // every accepted result word goes to the checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // watchdog: any handshake on any port counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("constant_time_clear_array_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // input-side gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (tx_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one operation word; returns at the edge where it was taken
  task automatic send_op(kind_t kind, logic [9:0] pos, logic [31:0] wval);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {6'd0, wval, pos};
    do @(posedge clk); while (!in_tready);
    sb.note_op(kind, pos, wval);
  endtask

  // drain everything outstanding, let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write of the size register, only with the array idle
  task automatic write_size(logic [10:0] v);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_ARRAY_SIZE;
    cfg_pwdata <= {21'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_size(v);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // random words: mostly writes and reads, reuse of a few low positions so
  // that reads hit live entries, rare clears, some out-of-range positions
  task automatic random_ops(int count);
    int done;
    int r;
    int lim;
    kind_t kind;
    logic [9:0] pos;
    done = 0;
    lim = (sb.size_limit == 0) ? 0 :
          (sb.size_limit > DEPTH) ? DEPTH - 1 : sb.size_limit - 1;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 45) kind = KIND_WRITE;
      else if (r < 91) kind = KIND_READ;
      else if (r < 94) kind = KIND_CLEAR;
      else kind = KIND_SPARE;
      r = $urandom_range(0, 99);
      if (r < 35) pos = 10'($urandom_range(0, (lim < 15) ? lim : 15));
      else if (r < 85) pos = 10'($urandom_range(0, lim));
      else pos = 10'($urandom_range(0, DEPTH - 1));
      send_op(kind, pos, $urandom);
      done++;
    end
  endtask

  int phase_size[8];
  int phase_count[8];

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_WRITE;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = ADDR_ARRAY_SIZE;
    cfg_pwdata = '0;
    tx_free = 1'b0;
    rx_free = 1'b0;
    rx_hold = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset size, cold reads, extremes of value and index
    send_op(KIND_READ,  10'd0,    32'h0000_0000);   // nothing live yet
    send_op(KIND_WRITE, 10'd0,    32'h8000_0000);
    send_op(KIND_WRITE, 10'd1023, 32'h7fff_ffff);
    send_op(KIND_READ,  10'd0,    32'hffff_ffff);
    send_op(KIND_READ,  10'd1023, 32'h0000_0000);
    send_op(KIND_READ,  10'd512,  32'h0000_0000);   // never written
    send_op(KIND_WRITE, 10'd0,    32'hffff_ffff);   // rewrite of a live entry
    send_op(KIND_READ,  10'd0,    32'h0000_0000);
    send_op(KIND_SPARE, 10'd1023, 32'hffff_ffff);
    send_op(KIND_CLEAR, 10'h2aa,  32'hdead_beef);   // clear ignores its fields
    send_op(KIND_READ,  10'd0,    32'h0000_0000);   // stale after clear
    send_op(KIND_READ,  10'd1023, 32'h0000_0000);
    send_op(KIND_WRITE, 10'h155,  32'h5555_5555);
    send_op(KIND_WRITE, 10'h2aa,  32'haaaa_aaaa);
    send_op(KIND_READ,  10'h155,  32'h0000_0000);
    send_op(KIND_READ,  10'h2aa,  32'h0000_0000);
    // size of one: only position zero is usable
    write_size(11'd1);
    send_op(KIND_WRITE, 10'd1,    32'h1234_5678);
    send_op(KIND_READ,  10'd1,    32'h0000_0000);
    send_op(KIND_READ,  10'd0,    32'h0000_0000);
    // size zero: every position invalid
    write_size(11'd0);
    send_op(KIND_WRITE, 10'd0,    32'h0000_0001);
    send_op(KIND_READ,  10'd0,    32'h0000_0000);
    send_op(KIND_CLEAR, 10'd0,    32'h0000_0000);
    // size above the depth acts as the depth
    write_size(11'd2047);
    send_op(KIND_WRITE, 10'd1023, 32'hcafe_f00d);
    send_op(KIND_READ,  10'd1023, 32'h0000_0000);

    // random phases over a spread of sizes, two of them without any idling
    phase_size  = '{16, 1024, 2047, 1, 0, 200, $urandom_range(2, 1023), 1024};
    phase_count = '{150, 200, 150, 40, 20, 150, 200, 190};
    for (int ph = 0; ph < 8; ph++) begin
      write_size(phase_size[ph][10:0]);
      tx_free = (ph == 2 || ph == 6);
      rx_free = (ph == 2 || ph == 6);
      random_ops(phase_count[ph]);
    end
    tx_free = 1'b0;
    rx_free = 1'b0;

    drain();
    if (sb.errors == 0) begin
      $display("constant_time_clear_array_top: match");
    end else begin
      $display("constant_time_clear_array_top: mismatch");
    end
    $finish;
  end

endmodule
